// ===== sv/pwl_pkg.sv =====
// shared types, constants and the generic torque curve for the curve lookup
`timescale 1ns / 1ps
`default_nettype none
package pwl_pkg;

    localparam int MAX_POINTS_DEF = 16;
    localparam int GEN_POINTS     = 9;
    localparam int FRAC_BITS      = 16;
    localparam int STEP_W         = $clog2(FRAC_BITS);

    localparam logic CMD_QUERY = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef struct packed {
        logic        command;
        logic [3:0]  point_index;
        logic [15:0] point_rpm;
        logic [15:0] point_torque;
        logic [15:0] query_rpm;
    } in_t;

    typedef struct packed {
        logic [15:0] torque_out;
        logic        from_generic;
    } out_t;

    typedef struct packed {
        logic                 start;
        logic [FRAC_BITS-1:0] dividend;
        logic [FRAC_BITS-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [FRAC_BITS-1:0] quotient;
    } div_rsp_t;

    typedef struct packed {
        logic                 start;
        logic [FRAC_BITS-1:0] frac;
        logic signed [16:0]   delta;
    } mul_req_t;

    typedef struct packed {
        logic               done;
        logic signed [16:0] scaled;
    } mul_rsp_t;

    // built-in curve, rpm axis
    function automatic logic [15:0] gen_rpm(input logic [3:0] idx);
        logic [15:0] r;
        unique case (idx)
            4'd0:    r = 16'd800;
            4'd1:    r = 16'd1000;
            4'd2:    r = 16'd2000;
            4'd3:    r = 16'd3000;
            4'd4:    r = 16'd4000;
            4'd5:    r = 16'd5000;
            4'd6:    r = 16'd6000;
            4'd7:    r = 16'd7000;
            4'd8:    r = 16'd8000;
            default: r = 16'd8000;
        endcase
        return r;
    endfunction

    // built-in curve, torque in q2.14
    function automatic logic [15:0] gen_torque(input logic [3:0] idx);
        logic [15:0] v;
        unique case (idx)
            4'd0:    v = 16'd7373;
            4'd1:    v = 16'd9011;
            4'd2:    v = 16'd11469;
            4'd3:    v = 16'd13926;
            4'd4:    v = 16'd16384;
            4'd5:    v = 16'd15565;
            4'd6:    v = 16'd13926;
            4'd7:    v = 16'd12288;
            4'd8:    v = 16'd10650;
            default: v = 16'd10650;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== sv/pwl_ram.sv =====
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none
module pwl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== sv/pwl_div.sv =====
// bit-serial restoring divider for the segment fraction, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module pwl_div import pwl_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [STEP_W-1:0]    cnt_reg, cnt_next;
    logic [FRAC_BITS-1:0] rem_reg, rem_next;
    logic [FRAC_BITS-1:0] quo_reg, quo_next;
    logic [FRAC_BITS-1:0] dvs_reg, dvs_next;
    logic [FRAC_BITS:0]   rem2;
    logic [FRAC_BITS:0]   diff;
    logic                 qbit;

    // dividend below divisor, so it seeds the remainder directly
    always_comb begin
        rem2      = {rem_reg, 1'b0};
        diff      = rem2 - {1'b0, dvs_reg};
        qbit      = (rem2 >= {1'b0, dvs_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = req.dividend;
            dvs_next  = req.divisor;
            quo_next  = '0;
        end else if (busy_reg) begin
            rem_next = qbit ? diff[FRAC_BITS-1:0] : rem2[FRAC_BITS-1:0];
            quo_next = {quo_reg[FRAC_BITS-2:0], qbit};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == STEP_W'(FRAC_BITS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule
`default_nettype wire

// ===== sv/pwl_mul.sv =====
// bit-serial signed shift-add multiplier, gives floor(frac * delta / 65536)
`timescale 1ns / 1ps
`default_nettype none
module pwl_mul import pwl_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire mul_req_t req,
    output mul_rsp_t      rsp
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [STEP_W-1:0]    cnt_reg, cnt_next;
    logic [FRAC_BITS-1:0] frac_reg, frac_next;
    logic signed [16:0]   dlt_reg, dlt_next;
    logic signed [16:0]   acc_reg, acc_next;
    logic signed [17:0]   sum;

    // lsb first; the arithmetic shift each step floors, and nested floors compose
    always_comb begin
        sum       = {acc_reg[16], acc_reg}
                  + (frac_reg[0] ? {dlt_reg[16], dlt_reg} : 18'sd0);
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        frac_next = frac_reg;
        dlt_next  = dlt_reg;
        acc_next  = acc_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            frac_next = req.frac;
            dlt_next  = req.delta;
            acc_next  = '0;
        end else if (busy_reg) begin
            acc_next  = sum[17:1];
            frac_next = {1'b0, frac_reg[FRAC_BITS-1:1]};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == STEP_W'(FRAC_BITS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg  <= cnt_next;
        frac_reg <= frac_next;
        dlt_reg  <= dlt_next;
        acc_reg  <= acc_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.scaled = acc_reg;

endmodule
`default_nettype wire

// ===== sv/piecewise_linear_curve_lookup.sv =====
// top level of the piecewise-linear torque curve lookup
`timescale 1ns / 1ps
`default_nettype none
// Torque curve lookup. A request with command 1 stores one breakpoint (rpm and
// q2.14 torque) in slot point_index and returns nothing. A request with
// command 0 returns the torque at query_rpm: the first point's torque at or
// below the first rpm, the last point's torque at or above the last rpm, else
// a linear blend on the first segment whose upper rpm exceeds the query.
// point_count (written on cfg_we) gives the number of loaded points; the user
// must write it only while idle, as the block does not enforce this. Zero
// selects the built-in nine-point curve, flagged by from_generic. A query walks
// the table through the single ram read port, one point per cycle, then an
// interior query goes through the bit-serial fraction divider and the
// bit-serial multiplier. A new request is taken while a finished result waits
// on m_.
module piecewise_linear_curve_lookup import pwl_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_we,
    input  wire logic [4:0] cfg_wdata,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire in_t        s_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    output out_t            m_data
);

    localparam int AW   = $clog2(MAX_POINTS);
    localparam int NMAX = (MAX_POINTS > GEN_POINTS) ? MAX_POINTS : GEN_POINTS;
    localparam int IW   = $clog2(NMAX);
    localparam int SW   = $clog2(NMAX + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    // control state
    logic [2:0]  state_reg, state_next;
    logic [4:0]  point_count_reg, point_count_next;
    logic        ev_vld_reg, ev_vld_next;
    logic        m_valid_reg, m_valid_next;

    // query working registers
    logic [15:0]        x_reg, x_next;
    logic               gen_reg, gen_next;
    logic [SW-1:0]      n_reg, n_next;
    logic [SW-1:0]      rd_seq_reg, rd_seq_next;
    logic [SW-1:0]      ev_seq_reg, ev_seq_next;
    logic               ge_last_reg, ge_last_next;
    logic [15:0]        v_last_reg, v_last_next;
    logic [15:0]        prev_rpm_reg, prev_rpm_next;
    logic [15:0]        prev_trq_reg, prev_trq_next;
    logic [15:0]        t0_reg, t0_next;
    logic signed [16:0] dt_reg, dt_next;
    logic [15:0]        res_reg, res_next;
    logic [31:0]        gen_ent_reg;
    out_t               m_data_reg, m_data_next;

    logic           s_acc;
    logic           ram_we;
    logic [31:0]    ram_rdata;
    logic [IW-1:0]  rd_idx;
    logic [SW-1:0]  n_sel;
    logic [15:0]    cur_rpm;
    logic [15:0]    cur_trq;
    logic signed [16:0] dt_c;
    logic           fin_load;
    div_req_t       div_req;
    div_rsp_t       div_rsp;
    mul_req_t       mul_req;
    mul_rsp_t       mul_rsp;

    assign s_ready = (state_reg == ST_IDLE);
    assign s_acc   = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // writes land in the table while idle; slots past the depth are dropped
    assign ram_we = s_acc && (s_data.command == CMD_WRITE)
                  && (32'(s_data.point_index) < MAX_POINTS);

    // effective point count, saturated at the table depth
    always_comb begin
        if (point_count_reg == 5'd0) begin
            n_sel = SW'(GEN_POINTS);
        end else if (32'(point_count_reg) > MAX_POINTS) begin
            n_sel = SW'(MAX_POINTS);
        end else begin
            n_sel = SW'(point_count_reg);
        end
    end

    // read order: last point first, then points 0, 1, 2 ...
    assign rd_idx = (rd_seq_reg == '0) ? IW'(n_reg - 1'b1) : IW'(rd_seq_reg - 1'b1);

    pwl_ram #(
        .WIDTH (32),
        .DEPTH (MAX_POINTS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (AW'(s_data.point_index)),
        .wdata ({s_data.point_rpm, s_data.point_torque}),
        .raddr (rd_idx[AW-1:0]),
        .rdata (ram_rdata)
    );

    // built-in curve entry, registered to line up with the ram read
    always_ff @(posedge aclk) begin
        gen_ent_reg <= {gen_rpm(rd_idx[3:0]), gen_torque(rd_idx[3:0])};
    end

    assign cur_rpm = gen_reg ? gen_ent_reg[31:16] : ram_rdata[31:16];
    assign cur_trq = gen_reg ? gen_ent_reg[15:0]  : ram_rdata[15:0];
    assign dt_c    = $signed({1'b0, cur_trq}) - $signed({1'b0, prev_trq_reg});

    pwl_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    pwl_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    // fraction multiply starts the cycle the divider finishes
    assign mul_req.start = (state_reg == ST_DIV) && div_rsp.done;
    assign mul_req.frac  = div_rsp.quotient;
    assign mul_req.delta = dt_reg;

    assign fin_load = (state_reg == ST_FIN) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next       = state_reg;
        point_count_next = cfg_we ? cfg_wdata : point_count_reg;
        ev_vld_next      = 1'b0;
        x_next           = x_reg;
        gen_next         = gen_reg;
        n_next           = n_reg;
        rd_seq_next      = rd_seq_reg;
        ev_seq_next      = rd_seq_reg;
        ge_last_next     = ge_last_reg;
        v_last_next      = v_last_reg;
        prev_rpm_next    = prev_rpm_reg;
        prev_trq_next    = prev_trq_reg;
        t0_next          = t0_reg;
        dt_next          = dt_reg;
        res_next         = res_reg;
        m_data_next      = m_data_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        div_req.start    = 1'b0;
        div_req.dividend = x_reg - prev_rpm_reg;
        div_req.divisor  = cur_rpm - prev_rpm_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc && (s_data.command == CMD_QUERY)) begin
                    x_next      = s_data.query_rpm;
                    gen_next    = (point_count_reg == 5'd0);
                    n_next      = n_sel;
                    rd_seq_next = '0;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN: begin
                ev_vld_next = 1'b1;
                if (rd_seq_reg != n_reg) begin
                    rd_seq_next = rd_seq_reg + 1'b1;
                end
                if (ev_vld_reg) begin
                    priority if (ev_seq_reg == '0) begin
                        // last point, checked ahead of the walk
                        ge_last_next = (x_reg >= cur_rpm);
                        v_last_next  = cur_trq;
                    end else if (ev_seq_reg == SW'(1)) begin
                        if (x_reg <= cur_rpm) begin
                            res_next    = cur_trq;
                            ev_vld_next = 1'b0;
                            state_next  = ST_FIN;
                        end else if (ge_last_reg) begin
                            res_next    = v_last_reg;
                            ev_vld_next = 1'b0;
                            state_next  = ST_FIN;
                        end
                        prev_rpm_next = cur_rpm;
                        prev_trq_next = cur_trq;
                    end else begin
                        if (x_reg < cur_rpm) begin
                            // segment found: lo <= x < hi
                            div_req.start = 1'b1;
                            t0_next       = prev_trq_reg;
                            dt_next       = dt_c;
                            ev_vld_next   = 1'b0;
                            state_next    = ST_DIV;
                        end
                        prev_rpm_next = cur_rpm;
                        prev_trq_next = cur_trq;
                    end
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                if (mul_rsp.done) begin
                    res_next   = t0_reg + mul_rsp.scaled[15:0];
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (fin_load) begin
                    m_data_next.torque_out   = res_reg;
                    m_data_next.from_generic = gen_reg;
                    m_valid_next             = 1'b1;
                    state_next               = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            point_count_reg <= 5'd0;
            ev_vld_reg      <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            point_count_reg <= point_count_next;
            ev_vld_reg      <= ev_vld_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg        <= x_next;
        gen_reg      <= gen_next;
        n_reg        <= n_next;
        rd_seq_reg   <= rd_seq_next;
        ev_seq_reg   <= ev_seq_next;
        ge_last_reg  <= ge_last_next;
        v_last_reg   <= v_last_next;
        prev_rpm_reg <= prev_rpm_next;
        prev_trq_reg <= prev_trq_next;
        t0_reg       <= t0_next;
        dt_reg       <= dt_next;
        res_reg      <= res_next;
        m_data_reg   <= m_data_next;
    end

endmodule
`default_nettype wire

// ===== sv/pwl_checker.sv =====
// port-level checker for the curve lookup and its bind
`timescale 1ns / 1ps
`default_nettype none
module pwl_checker import pwl_pkg::*; (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       cfg_we,
    input wire logic [4:0] cfg_wdata,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire in_t        s_data,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire out_t       m_data
);

    logic [4:0] count_reg;
    logic [1:0] pend_reg;
    logic       q_in;
    logic       r_out;

    assign q_in  = s_valid && s_ready && (s_data.command == CMD_QUERY);
    assign r_out = m_valid && m_ready;

    // shadow of the count register and of queries still owed a result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 5'd0;
            pend_reg  <= 2'd0;
        end else begin
            if (cfg_we) begin
                count_reg <= cfg_wdata;
            end
            pend_reg <= pend_reg + {1'b0, q_in} - {1'b0, r_out};
        end
    end

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (pend_reg != 2'd0))
        else $error("result without a pending query");

    a_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg != 2'd3)
        else $error("more than two queries in flight");

    a_generic_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !$past(m_valid)) |-> (m_data.from_generic == (count_reg == 5'd0)))
        else $error("generic flag disagrees with point count");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled result changed");

endmodule

bind piecewise_linear_curve_lookup pwl_checker u_pwl_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_data    (s_data),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_data    (m_data)
);
`default_nettype wire
